>>> sv/run_coalescing_rank_accumulator_defines.svh
// Assertion macros for the run-coalescing rank accumulator checker.
// Stand-alone header; no other file is needed to use it.
`ifndef RUN_COALESCING_RANK_ACCUMULATOR_DEFINES_SVH
`define RUN_COALESCING_RANK_ACCUMULATOR_DEFINES_SVH

// Check a property on every clock edge, skipped while reset is high.
`define RCRA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RCRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/rcra_pkg.sv
// Shared types, codes and sizes of the run-coalescing rank accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package rcra_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

  // operation codes
  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_EXTEND = 2'd2;

  // table access kinds
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_ADD  = 2'd1;
  localparam logic [1:0] K_LOAD = 2'd2;
  localparam logic [1:0] K_READ = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
    logic [1:0]        status;
    logic [ADDR_W-1:0] largest;
  } issue_t;

  typedef struct packed {
    logic [31:0]       rank;
    logic [1:0]        status;
    logic [ADDR_W-1:0] largest;
  } result_t;

endpackage

`default_nettype wire

>>> sv/rcra_run_tracker.sv
// Run tracker: pending run, largest updated id and per-item table access decode.
// Depends on rcra_pkg.
`default_nettype none

module rcra_run_tracker
  import rcra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] doc_id,
  input  wire logic [31:0] load_value,
  input  wire logic [16:0] id_limit,
  output issue_t           issue
);

  logic [31:0]       pend_id;
  logic [30:0]       pend_count;
  logic              pend_valid;
  logic [ADDR_W-1:0] largest;

  logic same_id;
  logic pend_ok;
  logic in_ok;

  function automatic logic id_ok(input logic [31:0] id, input logic [16:0] lim);
    return (33'(id) < 33'(lim)) && (33'(id) < 33'(TABLE_DEPTH));
  endfunction

  assign same_id = pend_valid && (doc_id == pend_id);
  assign pend_ok = id_ok(pend_id, id_limit);
  assign in_ok   = id_ok(doc_id, id_limit);

  always_comb begin
    issue         = '0;
    issue.kind    = K_NONE;
    issue.status  = ST_OK;
    issue.largest = largest;
    case (op)
      OP_COUNT, OP_FLUSH: begin
        if (op == OP_COUNT && same_id) begin
          issue.status = ST_EXTEND;
        end else if (pend_valid) begin
          // commit the pending run to its own entry
          if (pend_ok) begin
            issue.kind = K_ADD;
            issue.addr = ADDR_W'(pend_id);
            issue.data = 32'(pend_count);
            if (pend_id > 32'(largest)) begin
              issue.largest = ADDR_W'(pend_id);
            end
          end else begin
            issue.status = ST_RANGE;
          end
        end
      end
      OP_READ: begin
        if (in_ok) begin
          issue.kind = K_READ;
          issue.addr = ADDR_W'(doc_id);
        end else begin
          issue.status = ST_RANGE;
        end
      end
      OP_LOAD: begin
        if (in_ok) begin
          issue.kind = K_LOAD;
          issue.addr = ADDR_W'(doc_id);
          issue.data = load_value;
        end else begin
          issue.status = ST_RANGE;
        end
      end
      default: begin
        issue.kind = K_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_id    <= '0;
      pend_count <= '0;
      pend_valid <= 1'b0;
      largest    <= '0;
    end else if (accept) begin
      largest <= issue.largest;
      if (op == OP_COUNT) begin
        if (same_id) begin
          if (pend_count < COUNT_MAX) begin
            pend_count <= pend_count + 31'd1;
          end
        end else begin
          pend_id    <= doc_id;
          pend_count <= 31'd1;
          pend_valid <= 1'b1;
        end
      end else if (op == OP_FLUSH && pend_valid) begin
        pend_valid <= 1'b0;
        pend_count <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/rcra_table.sv
// Rank table: synchronous memory, clearing sweep after reset, and the
// read-modify-write stage with forwarding of the last write. Depends on rcra_pkg.
`default_nettype none

module rcra_table
  import rcra_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   accept,
  input  wire issue_t issue,
  input  wire logic   advance,
  output logic        busy,
  output logic        s1_valid,
  output result_t     result
);

  logic [31:0] mem [TABLE_DEPTH];

  logic [ADDR_W-1:0] clr_addr;
  logic [31:0]       rd_data;
  issue_t            s1;

  logic              last_valid;
  logic [ADDR_W-1:0] last_addr;
  logic [31:0]       last_data;

  logic [31:0]       cur;
  logic [31:0]       wr_val;
  logic              wr_stage;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;

  // read-during-write on the same entry returns old data: take the last write
  assign cur = (last_valid && last_addr == s1.addr) ? last_data : rd_data;

  always_comb begin
    wr_val        = s1.data;
    wr_stage      = 1'b0;
    result.rank   = '0;
    result.status = s1.status;
    result.largest = s1.largest;
    case (s1.kind)
      K_ADD: begin
        wr_val      = cur + s1.data;
        wr_stage    = 1'b1;
        result.rank = wr_val;
      end
      K_LOAD: begin
        wr_stage    = 1'b1;
        result.rank = s1.data;
      end
      K_READ: begin
        result.rank = cur;
      end
      default: begin
        result.rank = '0;
      end
    endcase
  end

  assign we    = busy || (advance && wr_stage);
  assign waddr = busy ? clr_addr : s1.addr;
  assign wdata = busy ? 32'd0 : wr_val;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (accept) begin
      rd_data <= mem[issue.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= issue;
    end
    if (advance && wr_stage) begin
      last_addr <= s1.addr;
      last_data <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      last_valid <= 1'b0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance && wr_stage) begin
        last_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/run_coalescing_rank_accumulator.sv
// Top level of the run-coalescing rank accumulator.
// Depends on rcra_pkg, rcra_run_tracker and rcra_table.
//
// Input items arrive on the s_* stream: s_tuser carries the operation (count
// occurrence, read entry, preload entry, flush run), s_tdata the document id and
// the preload value. Every item yields exactly one result item on the m_* stream:
// rank and the largest updated id in m_tdata, status in m_tuser. id_limit is
// written through cfg_we / cfg_wdata; the user must write it only while no item
// is in flight; the block itself does not enforce this. The table is read at the
// accept edge; the add, the write back and the load of the output register
// happen when the table stage advances. The last write is forwarded, so items
// on the same entry run back to back; one item per cycle while m_tready is high.
// Reset: rst (synchronous) clears the pending run and the largest id and starts
// a clearing sweep of the table, one entry per cycle, while s_tready stays low;
// configuration writes are still taken.
// Stall: with m_tready low the result holds in the output register; one more
// item is accepted into the table stage, then s_tready drops.
`default_nettype none

module run_coalescing_rank_accumulator
  import rcra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] doc_id, [63:32] load_value
  input  wire logic [1:0]  s_tuser,   // [1:0] op
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [31:0] rank, [47:32] largest_id
  output logic [1:0]       m_tuser,   // [1:0] status
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_wdata  // id_limit
);

  logic [16:0] id_limit;
  logic        accept;
  logic        advance;
  logic        busy;
  logic        s1_valid;
  issue_t      issue;
  result_t     result;
  result_t     out_res;

  // advance the table stage whenever the output register is free or drains
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !busy && (!s1_valid || advance);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_limit <= 17'h10000;
    end else if (cfg_we) begin
      id_limit <= cfg_wdata;
    end
  end

  rcra_run_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (s_tuser),
    .doc_id     (s_tdata[31:0]),
    .load_value (s_tdata[63:32]),
    .id_limit   (id_limit),
    .issue      (issue)
  );

  rcra_table u_table (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .issue    (issue),
    .advance  (advance),
    .busy     (busy),
    .s1_valid (s1_valid),
    .result   (result)
  );

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tdata = {16'(out_res.largest), out_res.rank};
  assign m_tuser = out_res.status;

endmodule

`default_nettype wire

>>> sv/rcra_checker.sv
// Port-level checker for run_coalescing_rank_accumulator, with its bind.
// Depends on rcra_pkg and run_coalescing_rank_accumulator_defines.svh.
`default_nettype none

`include "run_coalescing_rank_accumulator_defines.svh"

module rcra_checker
  import rcra_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  logic [15:0] last_largest;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_largest <= '0;
    end else if (m_tvalid && m_tready) begin
      last_largest <= m_tdata[47:32];
    end
  end

  `RCRA_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!s_tready && !m_tvalid), "outputs active right after reset")
  `RCRA_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result item changed")
  `RCRA_ASSERT(a_rank_zero, clk, rst, (m_tvalid && (m_tuser == ST_RANGE || m_tuser == ST_EXTEND)) |-> (m_tdata[31:0] == 32'd0), "rank not zero without table access")
  `RCRA_ASSERT(a_largest_mono, clk, rst, m_tvalid |-> (m_tdata[47:32] >= last_largest), "largest id went down")

endmodule

bind run_coalescing_rank_accumulator rcra_checker u_checker (.*);

`default_nettype wire
